@@ hdl/epc_pkg.sv @@
// Shared widths and payload types for the elastic pair collision pipeline.
// No dependencies; used by the top level and the pipelined divider.
`timescale 1ns / 1ps
`default_nettype none
package epc_pkg;

    localparam int COORD_W    = 32;                  // Q16.16 position / velocity
    localparam int RAD_W      = 31;                  // unsigned Q15.16 radius
    localparam int MASS_W     = 16;                  // integer mass
    localparam int MSUM_W     = MASS_W + 1;          // ma + mb
    localparam int DIFF_W     = COORD_W + 1;         // d and dv components
    localparam int RSUM_W     = COORD_W;             // ra + rb
    localparam int RS2_W      = 2 * RSUM_W;          // (ra + rb)^2
    localparam int PROD_W     = 2 * DIFF_W;          // one 33x33 product
    localparam int DOT_W      = PROD_W + 1;          // dot and dist2
    localparam int MAG_W      = PROD_W;              // |dot| on a hit
    localparam int M1_W       = DIFF_W + MASS_W;     // |dc| * m
    localparam int CHUNK_W    = 22;                  // |dot| slice per partial product
    localparam int CHUNKS     = MAG_W / CHUNK_W;
    localparam int PART_W     = M1_W + CHUNK_W;
    localparam int NUM_W      = M1_W + MAG_W + 1;    // |dc| * |dot| * 2m
    localparam int DEN_W      = RS2_W + MSUM_W;      // dist2 * (ma + mb)
    localparam int QUO_W      = 36;                  // impulse magnitude bits
    localparam int RES_W      = QUO_W + 2;           // velocity +/- impulse
    localparam int LANES      = 4;                   // a_x, a_y, b_x, b_y
    localparam int IN_DATA_W  = 352;
    localparam int OUT_DATA_W = 136;

    localparam int LANE_AX = 0;
    localparam int LANE_AY = 1;
    localparam int LANE_BX = 2;
    localparam int LANE_BY = 3;

    typedef struct packed {
        logic [COORD_W-1:0] vax;
        logic [COORD_W-1:0] vay;
        logic [COORD_W-1:0] vbx;
        logic [COORD_W-1:0] vby;
        logic               neg_x;   // impulse x sign: set when dx >= 0
        logic               neg_y;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  hit;
        logic  apply;
    } div_side_t;

    localparam int SIDE_W = $bits(div_side_t);

endpackage
`default_nettype wire

@@ hdl/elastic_pair_collision.sv @@
// Top level of the 2D elastic pair collision pipeline.
// Depends on epc_pkg and epc_divider.
//
// Usage:
//   Slave channel s_*: one particle pair per request (positions, velocities,
//   radii, masses). Master channel m_*: one result per request, in order:
//   the collided flag and the four new velocities.
//   Throughput: one request per cycle, sustained while the receiver takes every result, with no bubbles.
//   Pipeline: six front stages form the differences, products, collision
//   test, denominator and numerators; the restoring divider takes 36 stages,
//   one quotient bit each; one stage applies the impulse and the output
//   register saturates.
//   All stages advance together while the output register is empty or taken;
//   when the receiver stalls, the whole pipeline holds, s_tready drops, and
//   no request is lost or repeated.
//   Reset (aresetn low, synchronous) clears every valid bit; data registers
//   keep their contents, which are never shown without a valid.
`timescale 1ns / 1ps
`default_nettype none
module elastic_pair_collision (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // pos_a_x, pos_a_y, vel_a_x, vel_a_y, pos_b_x, pos_b_y, vel_b_x, vel_b_y,
    // radius_a, radius_b, mass_a, mass_b (low bit up), zero padded
    input  wire  [epc_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // collided, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
    // (low bit up), zero padded
    output logic [epc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import epc_pkg::*;

    localparam int OFS_RA = 8 * COORD_W;
    localparam int OFS_RB = OFS_RA + RAD_W;
    localparam int OFS_MA = OFS_RB + RAD_W;
    localparam int OFS_MB = OFS_MA + MASS_W;
    localparam int USED_OUT = 1 + 4 * COORD_W;

    // global advance: every stage moves when the output slot frees
    logic adv;

    // input fields
    logic signed [COORD_W-1:0] pax, pay, vax, vay, pbx, pby, vbx, vby;
    logic [RAD_W-1:0]          rad_a, rad_b;
    logic [MASS_W-1:0]         mass_a, mass_b;

    assign pax    = s_tdata[0*COORD_W +: COORD_W];
    assign pay    = s_tdata[1*COORD_W +: COORD_W];
    assign vax    = s_tdata[2*COORD_W +: COORD_W];
    assign vay    = s_tdata[3*COORD_W +: COORD_W];
    assign pbx    = s_tdata[4*COORD_W +: COORD_W];
    assign pby    = s_tdata[5*COORD_W +: COORD_W];
    assign vbx    = s_tdata[6*COORD_W +: COORD_W];
    assign vby    = s_tdata[7*COORD_W +: COORD_W];
    assign rad_a  = s_tdata[OFS_RA +: RAD_W];
    assign rad_b  = s_tdata[OFS_RB +: RAD_W];
    assign mass_a = s_tdata[OFS_MA +: MASS_W];
    assign mass_b = s_tdata[OFS_MB +: MASS_W];

    // ---------------- stage 1: differences, radius and mass sums
    logic                     st1_v_reg;
    logic signed [DIFF_W-1:0] st1_dx_reg, st1_dy_reg, st1_dvx_reg, st1_dvy_reg;
    logic signed [DIFF_W-1:0] st1_dx_next, st1_dy_next;
    logic [RSUM_W-1:0]        st1_rs_reg;
    logic [MASS_W-1:0]        st1_ma_reg, st1_mb_reg;
    logic [MSUM_W-1:0]        st1_msum_reg;
    side_t                    st1_side_reg;

    assign st1_dx_next = DIFF_W'(pax) - DIFF_W'(pbx);
    assign st1_dy_next = DIFF_W'(pay) - DIFF_W'(pby);

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_dx_reg         <= st1_dx_next;
            st1_dy_reg         <= st1_dy_next;
            st1_dvx_reg        <= DIFF_W'(vax) - DIFF_W'(vbx);
            st1_dvy_reg        <= DIFF_W'(vay) - DIFF_W'(vby);
            st1_rs_reg         <= RSUM_W'(rad_a) + RSUM_W'(rad_b);
            st1_ma_reg         <= mass_a;
            st1_mb_reg         <= mass_b;
            st1_msum_reg       <= MSUM_W'(mass_a) + MSUM_W'(mass_b);
            st1_side_reg.vax   <= vax;
            st1_side_reg.vay   <= vay;
            st1_side_reg.vbx   <= vbx;
            st1_side_reg.vby   <= vby;
            // on a hit dot < 0, so the impulse on A opposes dc when dc >= 0
            st1_side_reg.neg_x <= ~st1_dx_next[DIFF_W-1];
            st1_side_reg.neg_y <= ~st1_dy_next[DIFF_W-1];
        end
    end

    // ---------------- stage 2: dot and distance products, magnitudes
    logic                     st2_v_reg;
    logic signed [PROD_W-1:0] st2_pdx_reg, st2_pdy_reg, st2_sqx_reg, st2_sqy_reg;
    logic [RS2_W-1:0]         st2_rs2_reg;
    logic [DIFF_W-1:0]        st2_adx_reg, st2_ady_reg;
    logic [MASS_W-1:0]        st2_ma_reg, st2_mb_reg;
    logic [MSUM_W-1:0]        st2_msum_reg;
    side_t                    st2_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_pdx_reg  <= st1_dvx_reg * st1_dx_reg;
            st2_pdy_reg  <= st1_dvy_reg * st1_dy_reg;
            st2_sqx_reg  <= st1_dx_reg * st1_dx_reg;
            st2_sqy_reg  <= st1_dy_reg * st1_dy_reg;
            st2_rs2_reg  <= RS2_W'(st1_rs_reg) * RS2_W'(st1_rs_reg);
            st2_adx_reg  <= st1_dx_reg[DIFF_W-1] ? DIFF_W'(-st1_dx_reg) : DIFF_W'(st1_dx_reg);
            st2_ady_reg  <= st1_dy_reg[DIFF_W-1] ? DIFF_W'(-st1_dy_reg) : DIFF_W'(st1_dy_reg);
            st2_ma_reg   <= st1_ma_reg;
            st2_mb_reg   <= st1_mb_reg;
            st2_msum_reg <= st1_msum_reg;
            st2_side_reg <= st1_side_reg;
        end
    end

    // ---------------- stage 3: dot, dist2, |dc| * mass per lane
    logic                        st3_v_reg;
    logic signed [DOT_W-1:0]     st3_dot_reg;
    logic [DOT_W-1:0]            st3_dist2_reg;
    logic [RS2_W-1:0]            st3_rs2_reg;
    logic [LANES-1:0][M1_W-1:0]  st3_m1_reg;
    logic [MSUM_W-1:0]           st3_msum_reg;
    side_t                       st3_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_dot_reg            <= DOT_W'(st2_pdx_reg) + DOT_W'(st2_pdy_reg);
            st3_dist2_reg          <= DOT_W'(st2_sqx_reg) + DOT_W'(st2_sqy_reg);
            st3_rs2_reg            <= st2_rs2_reg;
            st3_m1_reg[LANE_AX]    <= M1_W'(st2_adx_reg) * M1_W'(st2_mb_reg);
            st3_m1_reg[LANE_AY]    <= M1_W'(st2_ady_reg) * M1_W'(st2_mb_reg);
            st3_m1_reg[LANE_BX]    <= M1_W'(st2_adx_reg) * M1_W'(st2_ma_reg);
            st3_m1_reg[LANE_BY]    <= M1_W'(st2_ady_reg) * M1_W'(st2_ma_reg);
            st3_msum_reg           <= st2_msum_reg;
            st3_side_reg           <= st2_side_reg;
        end
    end

    // ---------------- stage 4: collision test, |dot|, denominator
    logic                        st4_v_reg;
    logic [MAG_W-1:0]            st4_mag_reg;
    logic [DEN_W-1:0]            st4_den_reg;
    logic [LANES-1:0][M1_W-1:0]  st4_m1_reg;
    div_side_t                   st4_dside_reg;
    logic                        st4_hit_next;

    assign st4_hit_next = st3_dot_reg[DOT_W-1] && (st3_dist2_reg <= DOT_W'(st3_rs2_reg));

    always_ff @(posedge aclk) begin
        if (adv) begin
            st4_mag_reg         <= MAG_W'(-st3_dot_reg);
            // dist2 fits RS2_W bits whenever the test holds
            st4_den_reg         <= DEN_W'(st3_dist2_reg[RS2_W-1:0]) * DEN_W'(st3_msum_reg);
            st4_m1_reg          <= st3_m1_reg;
            st4_dside_reg.side  <= st3_side_reg;
            st4_dside_reg.hit   <= st4_hit_next;
            st4_dside_reg.apply <= st4_hit_next && (st3_msum_reg != '0);
        end
    end

    // ---------------- stage 5: partial products of the numerators
    logic                                    st5_v_reg;
    logic [LANES-1:0][CHUNKS-1:0][PART_W-1:0] st5_part_reg;
    logic [DEN_W-1:0]                        st5_den_reg;
    div_side_t                               st5_dside_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                for (int k = 0; k < CHUNKS; k++) begin
                    st5_part_reg[l][k] <= PART_W'(st4_m1_reg[l]) *
                                          PART_W'(st4_mag_reg[k*CHUNK_W +: CHUNK_W]);
                end
            end
            st5_den_reg   <= st4_den_reg;
            st5_dside_reg <= st4_dside_reg;
        end
    end

    // ---------------- stage 6: sum the partials, fold in the factor two
    logic                        st6_v_reg;
    logic [LANES-1:0][NUM_W-1:0] st6_num_reg;
    logic [LANES-1:0][NUM_W-1:0] st6_num_next;
    logic [DEN_W-1:0]            st6_den_reg;
    div_side_t                   st6_dside_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            st6_num_next[l] = '0;
            for (int k = 0; k < CHUNKS; k++) begin
                st6_num_next[l] = st6_num_next[l] +
                                  (NUM_W'(st5_part_reg[l][k]) << (k * CHUNK_W + 1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st6_num_reg   <= st6_num_next;
            st6_den_reg   <= st5_den_reg;
            st6_dside_reg <= st5_dside_reg;
        end
    end

    // ---------------- divider: QUO_W stages
    logic                        dv_valid;
    logic [LANES-1:0][QUO_W-1:0] dv_quo;
    logic [SIDE_W-1:0]           dv_side_bits;
    div_side_t                   dv_side;

    epc_divider #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .QUO_W  (QUO_W),
        .LANES  (LANES),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (st6_v_reg),
        .num       (st6_num_reg),
        .den       (st6_den_reg),
        .in_side   (st6_dside_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_side  (dv_side_bits)
    );

    assign dv_side = div_side_t'(dv_side_bits);

    // ---------------- stage 7: apply the signed impulses
    logic                    st7_v_reg;
    logic                    st7_hit_reg;
    logic signed [RES_W-1:0] st7_res_reg [LANES];
    logic signed [RES_W-1:0] st7_res_next [LANES];

    always_comb begin
        logic signed [RES_W-1:0] qx_a, qy_a, qx_b, qy_b;
        qx_a = dv_side.side.neg_x ? -RES_W'(dv_quo[LANE_AX]) : RES_W'(dv_quo[LANE_AX]);
        qy_a = dv_side.side.neg_y ? -RES_W'(dv_quo[LANE_AY]) : RES_W'(dv_quo[LANE_AY]);
        qx_b = dv_side.side.neg_x ? -RES_W'(dv_quo[LANE_BX]) : RES_W'(dv_quo[LANE_BX]);
        qy_b = dv_side.side.neg_y ? -RES_W'(dv_quo[LANE_BY]) : RES_W'(dv_quo[LANE_BY]);
        st7_res_next[LANE_AX] = RES_W'($signed(dv_side.side.vax));
        st7_res_next[LANE_AY] = RES_W'($signed(dv_side.side.vay));
        st7_res_next[LANE_BX] = RES_W'($signed(dv_side.side.vbx));
        st7_res_next[LANE_BY] = RES_W'($signed(dv_side.side.vby));
        // pass velocities through unless the pair collided with some mass
        if (dv_side.apply) begin
            st7_res_next[LANE_AX] = st7_res_next[LANE_AX] - qx_a;
            st7_res_next[LANE_AY] = st7_res_next[LANE_AY] - qy_a;
            st7_res_next[LANE_BX] = st7_res_next[LANE_BX] + qx_b;
            st7_res_next[LANE_BY] = st7_res_next[LANE_BY] + qy_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st7_hit_reg <= dv_side.hit;
            for (int l = 0; l < LANES; l++) begin
                st7_res_reg[l] <= st7_res_next[l];
            end
        end
    end

    // ---------------- output register: saturate to 32 bits
    function automatic logic [COORD_W-1:0] sat32(input logic signed [RES_W-1:0] v);
        logic [COORD_W-1:0] r;
        if ((&v[RES_W-1:COORD_W-1]) || !(|v[RES_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end else if (v[RES_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic                           m_valid_reg;
    logic                           m_col_reg;
    logic [LANES-1:0][COORD_W-1:0]  m_vel_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_col_reg <= st7_hit_reg;
            for (int l = 0; l < LANES; l++) begin
                m_vel_reg[l] <= sat32(st7_res_reg[l]);
            end
        end
    end

    // valid chain for the stages outside the divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg   <= 1'b0;
            st2_v_reg   <= 1'b0;
            st3_v_reg   <= 1'b0;
            st4_v_reg   <= 1'b0;
            st5_v_reg   <= 1'b0;
            st6_v_reg   <= 1'b0;
            st7_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_v_reg   <= s_tvalid;
            st2_v_reg   <= st1_v_reg;
            st3_v_reg   <= st2_v_reg;
            st4_v_reg   <= st3_v_reg;
            st5_v_reg   <= st4_v_reg;
            st6_v_reg   <= st5_v_reg;
            st7_v_reg   <= dv_valid;
            m_valid_reg <= st7_v_reg;
        end
    end

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-USED_OUT){1'b0}},
                       m_vel_reg[LANE_BY], m_vel_reg[LANE_BX],
                       m_vel_reg[LANE_AY], m_vel_reg[LANE_AX], m_col_reg};

    // ---------------- assertions
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted while the output stalls");

    a_apply_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid && dv_side.apply) |-> dv_side.hit)
        else $error("impulse applied without a collision");

    a_valid_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && st7_v_reg) |=> m_tvalid)
        else $error("finished result dropped before the output register");

endmodule
`default_nettype wire

@@ hdl/epc_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, several numerator
// lanes over one shared denominator, with a side payload. Uses epc_pkg defaults.
`timescale 1ns / 1ps
`default_nettype none
module epc_divider #(
    parameter int NUM_W  = epc_pkg::NUM_W,
    parameter int DEN_W  = epc_pkg::DEN_W,
    parameter int QUO_W  = epc_pkg::QUO_W,
    parameter int LANES  = epc_pkg::LANES,
    parameter int SIDE_W = epc_pkg::SIDE_W
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              en,
    input  wire                              in_valid,
    input  wire [LANES-1:0][NUM_W-1:0]       num,
    input  wire [DEN_W-1:0]                  den,
    input  wire [SIDE_W-1:0]                 in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][QUO_W-1:0]      quo,
    output logic [SIDE_W-1:0]                out_side
);

    logic [QUO_W-1:0]  v_reg;
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  low_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  quo_reg  [QUO_W][LANES];

    logic [DEN_W-1:0]  rem_src  [QUO_W][LANES];
    logic [QUO_W-1:0]  low_src  [QUO_W][LANES];
    logic [QUO_W-1:0]  quo_src  [QUO_W][LANES];
    logic [DEN_W-1:0]  den_src  [QUO_W];
    logic [DEN_W-1:0]  rem_next [QUO_W][LANES];
    logic [QUO_W-1:0]  low_next [QUO_W][LANES];
    logic [QUO_W-1:0]  quo_next [QUO_W][LANES];

    // stage inputs: the first stage loads the numerator high part as remainder
    always_comb begin
        den_src[0] = den;
        for (int l = 0; l < LANES; l++) begin
            rem_src[0][l] = DEN_W'(num[l][NUM_W-1:QUO_W]);
            low_src[0][l] = num[l][QUO_W-1:0];
            quo_src[0][l] = '0;
        end
        for (int j = 1; j < QUO_W; j++) begin
            den_src[j] = den_reg[j-1];
            for (int l = 0; l < LANES; l++) begin
                rem_src[j][l] = rem_reg[j-1][l];
                low_src[j][l] = low_reg[j-1][l];
                quo_src[j][l] = quo_reg[j-1][l];
            end
        end
    end

    // one shift, compare and subtract per stage and lane
    always_comb begin
        logic [DEN_W:0] t;
        logic           ge;
        t  = '0;
        ge = 1'b0;
        for (int j = 0; j < QUO_W; j++) begin
            for (int l = 0; l < LANES; l++) begin
                t  = {rem_src[j][l], low_src[j][l][QUO_W-1]};
                ge = (t >= {1'b0, den_src[j]});
                rem_next[j][l] = ge ? DEN_W'(t - {1'b0, den_src[j]}) : DEN_W'(t);
                low_next[j][l] = {low_src[j][l][QUO_W-2:0], 1'b0};
                quo_next[j][l] = {quo_src[j][l][QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int j = 0; j < QUO_W; j++) begin
                den_reg[j] <= den_src[j];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[j][l] <= rem_next[j][l];
                    low_reg[j][l] <= low_next[j][l];
                    quo_reg[j][l] <= quo_next[j][l];
                end
            end
            for (int j = 1; j < QUO_W; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb begin
        out_valid = v_reg[QUO_W-1];
        out_side  = side_reg[QUO_W-1];
        for (int l = 0; l < LANES; l++) begin
            quo[l] = quo_reg[QUO_W-1][l];
        end
    end

endmodule
`default_nettype wire
